[rtl/ntcb_pkg.sv]
// Shared constants, types and register codes for the thermistor converter.
package ntcb_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int SCALE_W      = 16;
  localparam int NOMINAL_W    = 20;
  localparam int BETA_W       = 16;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA    = 2'd2;

  localparam logic [SCALE_W-1:0]   SCALE_RST   = 16'd4096;
  localparam logic [NOMINAL_W-1:0] NOMINAL_RST = 20'd100000;
  localparam logic [BETA_W-1:0]    BETA_RST    = 16'd3975;

  // log2 format: integer part plus fraction bits, Q1.30 mantissa
  localparam int FRAC_W = 24;
  localparam int LOGI_W = 5;
  localparam int LOG_W  = LOGI_W + FRAC_W;
  localparam int MANT_W = 31;

  localparam int LMAG_W = 29;
  localparam int TMAG_W = 30;
  localparam int DEN_W  = 34;
  localparam int D_W    = 33;
  localparam int BT_W   = 41;
  localparam int NUM_W  = 58;
  localparam int QUO_W  = 40;
  localparam int TEMP_W = 11;

  localparam logic [29:0] LN2_Q30  = 30'd744261118;
  localparam logic [24:0] T0_Q16   = 25'd19539558;
  localparam logic [24:0] KOFF_Q16 = 25'd17901158;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FAILED = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -11'sd273;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 11'sd1000;

  // what the last stage drives onto temp_celsius
  typedef enum logic [1:0] {
    K_CALC,
    K_ZERO,
    K_MIN,
    K_MAX
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] status;
  } ctl_t;

endpackage

[rtl/ntcb_in_if.sv]
// Sample input channel.
interface ntcb_in_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;
  logic                read_failed;

  modport source (output valid, output adc_code, output read_failed, input ready);
  modport sink   (input valid, input adc_code, input read_failed, output ready);
endinterface

[rtl/ntcb_out_if.sv]
// Temperature result channel.
interface ntcb_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] temp_celsius;
  logic [1:0]         status;

  modport source (output valid, output temp_celsius, output status, input ready);
  modport sink   (input valid, input temp_celsius, input status, output ready);
endinterface

[rtl/ntcb_cfg_if.sv]
// Register write channel.
interface ntcb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ntcb_log.sv]
// Scaling, range check and two parallel log2 pipelines (one squaring per stage).
module ntcb_log #(
  parameter int ADC_BITS = ntcb_pkg::ADC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [ADC_BITS-1:0]          adc_code,
  input  logic                         read_failed,
  input  logic [ntcb_pkg::SCALE_W-1:0] scale_factor,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output ntcb_pkg::ctl_t               dn_ctl,
  output logic [ntcb_pkg::LOG_W-1:0]   log_num,
  output logic [ntcb_pkg::LOG_W-1:0]   log_den
);
  import ntcb_pkg::*;

  localparam int AS_W = ADC_BITS + SCALE_W;
  localparam int X_W  = ADC_BITS + 12;
  localparam int NST  = 3 + FRAC_W;
  localparam logic [AS_W-1:0] FSQ =
    {{(AS_W-ADC_BITS){1'b0}}, {ADC_BITS{1'b1}}} << 12;

  function automatic logic [LOGI_W-1:0] msb_pos(input logic [X_W-1:0] x);
    logic [LOGI_W-1:0] p;
    p = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x[i]) p = LOGI_W'(i);
    end
    return p;
  endfunction

  function automatic logic [MANT_W-1:0] norm(input logic [X_W-1:0] x);
    logic [MANT_W-1:0] xe;
    logic [LOGI_W-1:0] sh;
    xe = {{(MANT_W-X_W){1'b0}}, x};
    sh = LOGI_W'(MANT_W - 1) - msb_pos(x);
    return xe << sh;
  endfunction

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  logic [AS_W-1:0] as0;
  logic            f0;
  logic [X_W-1:0]  n1, d1;
  ctl_t            ctl1;
  logic            out_rng;

  logic [MANT_W-1:0] mn [FRAC_W+1];
  logic [MANT_W-1:0] md [FRAC_W+1];
  logic [LOG_W-1:0]  ln [FRAC_W+1];
  logic [LOG_W-1:0]  ld [FRAC_W+1];
  ctl_t              cs [FRAC_W+1];

  logic [2*MANT_W-1:0] pn [FRAC_W];
  logic [2*MANT_W-1:0] pd [FRAC_W];

  always_comb begin
    rdy[NST] = dn_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign out_rng = (as0 == '0) || (as0 >= FSQ);

  always_comb begin
    for (int k = 0; k < FRAC_W; k++) begin
      pn[k] = {{MANT_W{1'b0}}, mn[k]} * {{MANT_W{1'b0}}, mn[k]};
      pd[k] = {{MANT_W{1'b0}}, md[k]} * {{MANT_W{1'b0}}, md[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) v[i] <= ((i == 0) ? up_valid : v[(i == 0) ? 0 : i-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      as0 <= AS_W'(adc_code) * AS_W'(scale_factor);
      f0  <= read_failed;
    end
    if (rdy[1]) begin
      ctl1.status <= f0 ? ST_FAILED : (out_rng ? ST_RANGE : ST_OK);
      ctl1.kind   <= (f0 || out_rng) ? K_ZERO : K_CALC;
      n1 <= X_W'(FSQ - as0);
      d1 <= X_W'(as0);
    end
    if (rdy[2]) begin
      mn[0] <= norm(n1);
      md[0] <= norm(d1);
      ln[0] <= {msb_pos(n1), {FRAC_W{1'b0}}};
      ld[0] <= {msb_pos(d1), {FRAC_W{1'b0}}};
      cs[0] <= ctl1;
    end
    for (int k = 0; k < FRAC_W; k++) begin
      if (rdy[3+k]) begin
        // square, renormalize to [1,2) and take one fraction bit
        mn[k+1] <= pn[k][2*MANT_W-1] ? pn[k][MANT_W +: MANT_W]
                                     : pn[k][MANT_W-1 +: MANT_W];
        md[k+1] <= pd[k][2*MANT_W-1] ? pd[k][MANT_W +: MANT_W]
                                     : pd[k][MANT_W-1 +: MANT_W];
        ln[k+1] <= ln[k] | (LOG_W'(pn[k][2*MANT_W-1]) << (FRAC_W-1-k));
        ld[k+1] <= ld[k] | (LOG_W'(pd[k][2*MANT_W-1]) << (FRAC_W-1-k));
        cs[k+1] <= cs[k];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v[NST-1];
  assign dn_ctl   = cs[FRAC_W];
  assign log_num  = ln[FRAC_W];
  assign log_den  = ld[FRAC_W];

endmodule

[rtl/ntcb_den.sv]
// ln scaling, beta-equation denominator and divider numerator.
module ntcb_den (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  ntcb_pkg::ctl_t              up_ctl,
  input  logic [ntcb_pkg::LOG_W-1:0]  log_num,
  input  logic [ntcb_pkg::LOG_W-1:0]  log_den,
  input  logic [ntcb_pkg::BETA_W-1:0] beta_value,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output ntcb_pkg::ctl_t              dn_ctl,
  output logic [ntcb_pkg::D_W-1:0]    den,
  output logic [ntcb_pkg::NUM_W-1:0]  num
);
  import ntcb_pkg::*;

  localparam int NST = 5;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  ctl_t              c0, c1, c2, c3, c4;
  logic              neg0, neg1, neg2;
  logic [LOG_W-1:0]  dmag0;
  logic [BT_W-1:0]   bt0, bt1, bt2, bt3;
  logic [LMAG_W-1:0] lmag1;
  logic [TMAG_W-1:0] tmag2;
  logic signed [DEN_W-1:0] den3;
  logic [D_W-1:0]    d4;
  logic [NUM_W-1:0]  n4;

  logic [59:0]       p1;
  logic [54:0]       p2;
  logic [DEN_W-1:0]  bsh;
  logic [NUM_W-1:0]  nsum;

  always_comb begin
    rdy[NST] = dn_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign p1   = 60'(dmag0) * 60'(LN2_Q30) + (60'd1 << 29);
  assign p2   = 55'(lmag1) * 55'(T0_Q16) + (55'd1 << 23);
  assign bsh  = DEN_W'(beta_value) << 16;
  assign nsum = (NUM_W'(bt3) << 16) + NUM_W'(den3[DEN_W-2:1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) v[i] <= ((i == 0) ? up_valid : v[(i == 0) ? 0 : i-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      neg0  <= log_den > log_num;
      dmag0 <= (log_den > log_num) ? (log_den - log_num) : (log_num - log_den);
      bt0   <= BT_W'(beta_value) * BT_W'(T0_Q16);
      c0    <= up_ctl;
    end
    if (rdy[1]) begin
      lmag1 <= p1[30 +: LMAG_W];
      neg1  <= neg0;
      bt1   <= bt0;
      c1    <= c0;
    end
    if (rdy[2]) begin
      tmag2 <= p2[24 +: TMAG_W];
      neg2  <= neg1;
      bt2   <= bt1;
      c2    <= c1;
    end
    if (rdy[3]) begin
      den3 <= neg2 ? ($signed(bsh) - $signed(DEN_W'(tmag2)))
                   : ($signed(bsh) + $signed(DEN_W'(tmag2)));
      bt3  <= bt2;
      c3   <= c2;
    end
    if (rdy[4]) begin
      c4.status <= c3.status;
      if (c3.kind != K_CALC) begin
        c4.kind <= c3.kind;
      end else if (beta_value == '0 || den3 < 0) begin
        c4.kind <= K_MIN;
      end else if (den3 == 0) begin
        c4.kind <= K_MAX;
      end else if (D_W'(nsum[NUM_W-1:QUO_W]) >= den3[D_W-1:0]) begin
        // quotient would reach 2^40
        c4.kind <= K_MAX;
      end else begin
        c4.kind <= K_CALC;
      end
      d4 <= den3[D_W-1:0];
      n4 <= nsum;
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v[NST-1];
  assign dn_ctl   = c4;
  assign den      = d4;
  assign num      = n4;

endmodule

[rtl/ntcb_div.sv]
// Restoring divider, one quotient bit per stage.
module ntcb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  ntcb_pkg::ctl_t             up_ctl,
  input  logic [ntcb_pkg::D_W-1:0]   den,
  input  logic [ntcb_pkg::NUM_W-1:0] num,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output ntcb_pkg::ctl_t             dn_ctl,
  output logic [ntcb_pkg::QUO_W-1:0] quo
);
  import ntcb_pkg::*;

  localparam int NST = QUO_W;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  logic [D_W-1:0]   rem [NST];
  logic [QUO_W-1:0] lo  [NST];
  logic [QUO_W-1:0] q   [NST];
  logic [D_W-1:0]   dd  [NST];
  ctl_t             cc  [NST];

  logic [D_W-1:0]   prem [NST];
  logic [QUO_W-1:0] plo  [NST];
  logic [QUO_W-1:0] pq   [NST];
  logic [D_W-1:0]   pd   [NST];
  ctl_t             pc   [NST];
  logic [D_W:0]     t    [NST];
  logic             ge   [NST];

  always_comb begin
    rdy[NST] = dn_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  always_comb begin
    prem[0] = D_W'(num[NUM_W-1:QUO_W]);
    plo[0]  = num[QUO_W-1:0];
    pq[0]   = '0;
    pd[0]   = den;
    pc[0]   = up_ctl;
    for (int j = 1; j < NST; j++) begin
      prem[j] = rem[j-1];
      plo[j]  = lo[j-1];
      pq[j]   = q[j-1];
      pd[j]   = dd[j-1];
      pc[j]   = cc[j-1];
    end
    for (int j = 0; j < NST; j++) begin
      t[j]  = {prem[j], plo[j][QUO_W-1]};
      ge[j] = t[j] >= {1'b0, pd[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) v[i] <= ((i == 0) ? up_valid : v[(i == 0) ? 0 : i-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NST; j++) begin
      if (rdy[j]) begin
        rem[j] <= ge[j] ? D_W'(t[j] - {1'b0, pd[j]}) : t[j][D_W-1:0];
        lo[j]  <= plo[j] << 1;
        q[j]   <= {pq[j][QUO_W-2:0], ge[j]};
        dd[j]  <= pd[j];
        cc[j]  <= pc[j];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v[NST-1];
  assign dn_ctl   = cc[NST-1];
  assign quo      = q[NST-1];

endmodule

[rtl/ntcb_fin.sv]
// Kelvin to Celsius, rounding, saturation and the output register.
module ntcb_fin (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  ntcb_pkg::ctl_t                     up_ctl,
  input  logic [ntcb_pkg::QUO_W-1:0]         quo,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output logic signed [ntcb_pkg::TEMP_W-1:0] temp_celsius,
  output logic [1:0]                         status
);
  import ntcb_pkg::*;

  localparam int NST  = 2;
  localparam int TC_W = QUO_W + 2;
  localparam int R_W  = TC_W - 16;

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  logic signed [TC_W-1:0] tc0;
  ctl_t                   c0;
  logic [TC_W-1:0]        rr;
  logic [R_W-1:0]         r;
  logic signed [TEMP_W-1:0] tval;

  always_comb begin
    rdy[NST] = dn_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  // round half away from zero on the magnitude
  always_comb begin
    if (tc0 >= 0) begin
      rr = TC_W'(tc0) + TC_W'(32768);
    end else begin
      rr = TC_W'(32768) - TC_W'(tc0);
    end
    r = rr[TC_W-1:16];
    case (c0.kind)
      K_ZERO:  tval = '0;
      K_MIN:   tval = TEMP_MIN;
      K_MAX:   tval = TEMP_MAX;
      default: begin
        if (tc0 >= 0) begin
          tval = (r > R_W'(1000)) ? TEMP_MAX : $signed(TEMP_W'(r));
        end else begin
          tval = (r > R_W'(273)) ? TEMP_MIN : -$signed(TEMP_W'(r));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) v[i] <= ((i == 0) ? up_valid : v[(i == 0) ? 0 : i-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      tc0 <= $signed(TC_W'(quo)) - $signed(TC_W'(KOFF_Q16));
      c0  <= up_ctl;
    end
    if (rdy[1]) begin
      temp_celsius <= tval;
      status       <= c0.status;
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v[NST-1];

endmodule

[rtl/thermistor_beta_to_celsius.sv]
// Pipeline order from input transfer to result: log, denominator, divide, out.
// Throughput: one sample per cycle unless stalled; every stage holds its own valid bit
// and a stage takes new data whenever it is empty or its successor moves, so bubbles
// close up under output backpressure. The 40-step divider and 24-step log2 set the depth.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults:
// scale 1.0, nominal 100000 ohm, beta 3975 K.
module thermistor_beta_to_celsius #(
  parameter int ADC_BITS = ntcb_pkg::ADC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  ntcb_in_if.sink     in_ch,
  ntcb_out_if.source  out_ch,
  ntcb_cfg_if.sink    cfg_ch
);
  import ntcb_pkg::*;

  logic [SCALE_W-1:0]   scale_factor;
  logic [NOMINAL_W-1:0] nominal_resistance;
  logic [BETA_W-1:0]    beta_value;

  // Register writes are always accepted; the nominal resistance cancels in
  // the ratio and is only held.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor       <= SCALE_RST;
      nominal_resistance <= NOMINAL_RST;
      beta_value         <= BETA_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SCALE:   scale_factor       <= cfg_ch.data[SCALE_W-1:0];
        REG_NOMINAL: nominal_resistance <= cfg_ch.data[NOMINAL_W-1:0];
        REG_BETA:    beta_value         <= cfg_ch.data[BETA_W-1:0];
        default: ;   // drop writes beyond the register list
      endcase
    end
  end

  logic             lg_valid, lg_ready;
  ctl_t             lg_ctl;
  logic [LOG_W-1:0] lg_num, lg_den;

  logic             dn_valid, dn_ready;
  ctl_t             dn_ctl;
  logic [D_W-1:0]   dn_den;
  logic [NUM_W-1:0] dn_num;

  logic             dv_valid, dv_ready;
  ctl_t             dv_ctl;
  logic [QUO_W-1:0] dv_quo;

  // Stage group 1: scale the code, check range, log2 of numerator and
  // denominator of the resistance ratio.
  ntcb_log #(
    .ADC_BITS(ADC_BITS)
  ) u_log (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (in_ch.valid),
    .up_ready    (in_ch.ready),
    .adc_code    (in_ch.adc_code),
    .read_failed (in_ch.read_failed),
    .scale_factor(scale_factor),
    .dn_valid    (lg_valid),
    .dn_ready    (lg_ready),
    .dn_ctl      (lg_ctl),
    .log_num     (lg_num),
    .log_den     (lg_den)
  );

  // Stage group 2: ln of the ratio, beta denominator, special cases.
  ntcb_den u_den (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (lg_valid),
    .up_ready  (lg_ready),
    .up_ctl    (lg_ctl),
    .log_num   (lg_num),
    .log_den   (lg_den),
    .beta_value(beta_value),
    .dn_valid  (dn_valid),
    .dn_ready  (dn_ready),
    .dn_ctl    (dn_ctl),
    .den       (dn_den),
    .num       (dn_num)
  );

  // Stage group 3: kelvin in Q.16 by long division.
  ntcb_div u_div (
    .clk     (clk),
    .rst     (rst),
    .up_valid(dn_valid),
    .up_ready(dn_ready),
    .up_ctl  (dn_ctl),
    .den     (dn_den),
    .num     (dn_num),
    .dn_valid(dv_valid),
    .dn_ready(dv_ready),
    .dn_ctl  (dv_ctl),
    .quo     (dv_quo)
  );

  // Stage group 4: Celsius, round, saturate, hold the result for transfer.
  ntcb_fin u_fin (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (dv_valid),
    .up_ready    (dv_ready),
    .up_ctl      (dv_ctl),
    .quo         (dv_quo),
    .dn_valid    (out_ch.valid),
    .dn_ready    (out_ch.ready),
    .temp_celsius(out_ch.temp_celsius),
    .status      (out_ch.status)
  );

endmodule
